FILE: hw/rtl/srlt_pkg.sv
package srlt_pkg;

   // Section kinds reported by a lookup
   typedef enum logic [3:0] {
      KIND_UNKNOWN = 4'd0,
      KIND_CODE    = 4'd1,
      KIND_RODATA  = 4'd2,
      KIND_DATA    = 4'd3,
      KIND_BSS     = 4'd4,
      KIND_SYMTAB  = 4'd5,
      KIND_STRTAB  = 4'd6,
      KIND_RELOC   = 4'd7,
      KIND_HASH    = 4'd8,
      KIND_DYNAMIC = 4'd9,
      KIND_OTHER   = 4'd10
   } kind_type;

   // Transaction codes; the fourth code is a no-op
   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   // ELF section type words
   localparam logic [31:0] SHT_SYMTAB   = 32'd2;
   localparam logic [31:0] SHT_STRTAB   = 32'd3;
   localparam logic [31:0] SHT_RELA     = 32'd4;
   localparam logic [31:0] SHT_HASH     = 32'd5;
   localparam logic [31:0] SHT_DYNAMIC  = 32'd6;
   localparam logic [31:0] SHT_NOBITS   = 32'd8;
   localparam logic [31:0] SHT_REL      = 32'd9;
   localparam logic [31:0] SHT_DYNSYM   = 32'd11;
   localparam logic [31:0] SHT_GNU_HASH = 32'h6fff_fff6;

   // Flag bit positions
   localparam int FLAG_WRITE_BIT = 0;
   localparam int FLAG_ALLOC_BIT = 1;
   localparam int FLAG_EXEC_BIT  = 2;

   // Name classes
   localparam logic [1:0] NAME_EMPTY  = 2'd0;
   localparam logic [1:0] NAME_STRTAB = 2'd1;

   // One stored section range
   typedef struct packed {
      logic [63:0] base;
      logic [63:0] size;
      kind_type    kind;
   } entry_type;

   // Metadata kinds are symtab through dynamic
   function automatic logic kind_is_meta(kind_type k);
      return (k == KIND_SYMTAB) || (k == KIND_STRTAB) || (k == KIND_RELOC) ||
             (k == KIND_HASH) || (k == KIND_DYNAMIC);
   endfunction

endpackage

FILE: hw/rtl/srlt_classify.sv
module srlt_classify
   import srlt_pkg::*;
(
   input  logic [31:0] sec_type,
   input  logic [2:0]  sec_flag_bits,
   input  logic [1:0]  name_class,
   output kind_type    kind
);

   logic type_hit;
   kind_type type_kind;
   kind_type flag_kind;

   // Classify by section type word first
   always_comb begin
      type_hit  = 1'b1;
      type_kind = KIND_OTHER;
      unique case (sec_type)
         SHT_SYMTAB, SHT_DYNSYM: type_kind = KIND_SYMTAB;
         SHT_STRTAB: begin
            if (name_class == NAME_EMPTY || name_class == NAME_STRTAB) begin
               type_kind = KIND_STRTAB;
            end else begin
               type_kind = KIND_OTHER;
            end
         end
         SHT_RELA, SHT_REL:        type_kind = KIND_RELOC;
         SHT_HASH, SHT_GNU_HASH:   type_kind = KIND_HASH;
         SHT_DYNAMIC:              type_kind = KIND_DYNAMIC;
         SHT_NOBITS:               type_kind = KIND_BSS;
         default:                  type_hit  = 1'b0;
      endcase
   end

   // Fall back on flags: execute, then write, then alloc
   always_comb begin
      priority if (sec_flag_bits[FLAG_EXEC_BIT]) begin
         flag_kind = KIND_CODE;
      end else if (sec_flag_bits[FLAG_WRITE_BIT]) begin
         flag_kind = KIND_DATA;
      end else if (sec_flag_bits[FLAG_ALLOC_BIT]) begin
         flag_kind = KIND_RODATA;
      end else begin
         flag_kind = KIND_OTHER;
      end
   end

   assign kind = type_hit ? type_kind : flag_kind;

endmodule

FILE: hw/rtl/section_range_lookup_table_unit.sv
// Sorted table of up to MAX_SECTIONS section address ranges held in one
// 1-write/1-read synchronous memory. Raise start with a transaction while
// busy is low; every transaction produces exactly one result, driven for a
// single cycle with rsp_valid high, and the receiver has no way to hold it
// off, so it must take it on that cycle. Clear, a no-op code, an insert
// into a full table and a lookup in an empty table keep busy low and
// return their result on the next cycle. An insert walks the table from
// the top down, moving one entry up per cycle until it finds its slot. A
// lookup walks from the bottom up, one entry per cycle, until an entry
// starts above the address or the table ends. For both, the result
// appears on the cycle busy falls. The single memory read port, one
// entry per cycle, sets the pace of both walks.
module section_range_lookup_table_unit
   import srlt_pkg::*;
#(
   parameter int MAX_SECTIONS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_sec_start,
   input  logic [63:0] req_sec_length,
   input  logic [31:0] req_sec_type,
   input  logic [2:0]  req_sec_flag_bits,
   input  logic [1:0]  req_name_class,
   input  logic [63:0] req_query_addr,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [3:0]  rsp_kind,
   output logic [63:0] rsp_offset,
   output logic        rsp_in_metadata,
   output logic [$clog2(MAX_SECTIONS + 1) - 1:0] rsp_entry_total,
   output logic [$clog2(MAX_SECTIONS + 1) - 1:0] rsp_metadata_total,
   output logic [63:0] rsp_span_end,
   output logic        rsp_table_full
);

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_LK_RD,
      ST_LK_SCAN
   } state_type;

   // Entry memory
   entry_type mem [MAX_SECTIONS];
   entry_type rd_q;
   logic      rd_en;
   logic [IDX_W - 1:0] rd_addr;
   logic      wr_en;
   logic [IDX_W - 1:0] wr_addr;
   entry_type wr_data;

   // Control and held transaction
   state_type state_ff, state_in;
   logic [IDX_W - 1:0] cur_ff, cur_in;
   logic [CNT_W - 1:0] used_ff, used_in;
   logic [CNT_W - 1:0] meta_ff, meta_in;
   logic [63:0] max_end_ff, max_end_in;
   entry_type   new_ff, new_in;
   logic [63:0] query_ff, query_in;
   logic        found_ff, found_in;
   kind_type    best_kind_ff, best_kind_in;
   logic [63:0] best_off_ff, best_off_in;
   logic        meta_hit_ff, meta_hit_in;

   // Result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_offset_ff, rsp_offset_in;
   logic        rsp_meta_ff, rsp_meta_in;
   logic        rsp_full_ff, rsp_full_in;
   logic [CNT_W - 1:0] rsp_used_ff, rsp_used_in;
   logic [CNT_W - 1:0] rsp_mcnt_ff, rsp_mcnt_in;
   logic [63:0] rsp_end_ff, rsp_end_in;

   kind_type    new_kind;
   logic        accept;
   logic [63:0] req_end;
   logic [IDX_W - 1:0] last_idx;
   logic        entry_after;
   logic [63:0] rd_end;
   logic        rd_past;
   logic        rd_contains;
   logic        finish;

   srlt_classify u_classify (
      .sec_type      (req_sec_type),
      .sec_flag_bits (req_sec_flag_bits),
      .name_class    (req_name_class),
      .kind          (new_kind)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign req_end  = req_sec_start + req_sec_length;
   assign last_idx = IDX_W'(used_ff - CNT_W'(1));

   // Compare the entry just read against the held insert or query
   assign entry_after = !((rd_q.base < new_ff.base) ||
                          ((rd_q.base == new_ff.base) && (rd_q.size >= new_ff.size)));
   assign rd_end      = rd_q.base + rd_q.size;
   assign rd_past     = rd_q.base > query_ff;
   assign rd_contains = (rd_q.size != 64'd0) && (query_ff < rd_end);

   // Sequence transactions
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      used_in      = used_ff;
      meta_in      = meta_ff;
      max_end_in   = max_end_ff;
      new_in       = new_ff;
      query_in     = query_ff;
      found_in     = found_ff;
      best_kind_in = best_kind_ff;
      best_off_in  = best_off_ff;
      meta_hit_in  = meta_hit_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = new_ff;
      finish       = 1'b0;
      rsp_full_in  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in   = '{base: req_sec_start, size: req_sec_length, kind: new_kind};
               query_in = req_query_addr;
               unique case (req_action)
                  ACT_CLEAR: begin
                     used_in    = '0;
                     meta_in    = '0;
                     max_end_in = '0;
                     finish     = 1'b1;
                  end
                  ACT_INSERT: begin
                     if (used_ff >= CNT_W'(MAX_SECTIONS)) begin
                        rsp_full_in = 1'b1;
                        finish      = 1'b1;
                     end else begin
                        used_in = used_ff + CNT_W'(1);
                        if (kind_is_meta(new_kind)) begin
                           meta_in = meta_ff + CNT_W'(1);
                        end
                        if (req_end > max_end_ff) begin
                           max_end_in = req_end;
                        end
                        if (used_ff == '0) begin
                           cur_in   = '0;
                           state_in = ST_INS_PUT;
                        end else begin
                           cur_in   = last_idx;
                           state_in = ST_INS_RD;
                        end
                     end
                  end
                  ACT_LOOKUP: begin
                     found_in     = 1'b0;
                     best_kind_in = KIND_UNKNOWN;
                     best_off_in  = '0;
                     meta_hit_in  = 1'b0;
                     cur_in       = '0;
                     if (used_ff == '0) begin
                        finish = 1'b1;
                     end else begin
                        state_in = ST_LK_RD;
                     end
                  end
                  default: finish = 1'b1;
               endcase
            end
         end
         ST_INS_RD: begin
            rd_en    = 1'b1;
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff + IDX_W'(1);
            if (entry_after) begin
               // move entry up one slot, read the one below
               wr_data = rd_q;
               if (cur_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = cur_ff - IDX_W'(1);
                  cur_in   = cur_ff - IDX_W'(1);
               end
            end else begin
               wr_data  = new_ff;
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = new_ff;
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LK_RD: begin
            rd_en    = 1'b1;
            state_in = ST_LK_SCAN;
         end
         ST_LK_SCAN: begin
            if (!rd_past && rd_contains) begin
               found_in     = 1'b1;
               best_kind_in = rd_q.kind;
               best_off_in  = query_ff - rd_q.base;
               if (kind_is_meta(rd_q.kind)) begin
                  meta_hit_in = 1'b1;
               end
            end
            if (rd_past || (cur_ff == last_idx)) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff + IDX_W'(1);
               cur_in  = cur_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Form the result on the finishing cycle
   always_comb begin
      rsp_valid_in = finish;
      rsp_hit_in   = 1'b0;
      rsp_kind_in  = KIND_UNKNOWN;
      rsp_offset_in = '0;
      rsp_meta_in  = 1'b0;
      rsp_used_in  = used_in;
      rsp_mcnt_in  = meta_in;
      rsp_end_in   = max_end_in;
      if (state_ff == ST_LK_SCAN) begin
         rsp_hit_in    = found_in;
         rsp_kind_in   = best_kind_in;
         rsp_offset_in = best_off_in;
         rsp_meta_in   = meta_hit_in;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         meta_ff      <= '0;
         max_end_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         meta_ff      <= meta_in;
         max_end_ff   <= max_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      new_ff       <= new_in;
      query_ff     <= query_in;
      found_ff     <= found_in;
      best_kind_ff <= best_kind_in;
      best_off_ff  <= best_off_in;
      meta_hit_ff  <= meta_hit_in;
      if (finish) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_meta_ff   <= rsp_meta_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_mcnt_ff   <= rsp_mcnt_in;
         rsp_end_ff    <= rsp_end_in;
      end
   end

   // Entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_in_metadata    = rsp_meta_ff;
   assign rsp_entry_total    = rsp_used_ff;
   assign rsp_metadata_total = rsp_mcnt_ff;
   assign rsp_span_end       = rsp_end_ff;
   assign rsp_table_full     = rsp_full_ff;

endmodule
